// ===== hw/rtl/brtv_pkg.sv =====
package brtv_pkg;

   // Input beat: one raster pixel with its framing marks.
   typedef struct packed {
      logic pixel;
      logic end_of_line;
      logic start_of_page;
   } req_beat_type;

   // Output beat: one byte of the terminal command stream.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_beat_type;

   // Byte slots of one pixel's command, in emission order.
   localparam int SLOT_GRAPH_START = 0;
   localparam int SLOT_A0_Y_HIGH   = 1;
   localparam int SLOT_A0_Y_LOW    = 2;
   localparam int SLOT_A0_X_HIGH   = 3;
   localparam int SLOT_A0_X_LOW    = 4;
   localparam int SLOT_A1_Y_HIGH   = 5;
   localparam int SLOT_A1_Y_LOW    = 6;
   localparam int SLOT_A1_X_HIGH   = 7;
   localparam int SLOT_A1_X_LOW    = 8;
   localparam int NUM_SLOTS        = 9;

   // Command handed from the classifier to the byte sequencer.
   // Both addresses of one pixel share the same y.
   typedef struct packed {
      logic [NUM_SLOTS-1:0] slot_mask;
      logic [9:0]           y;
      logic [9:0]           addr0_x;
      logic [9:0]           addr1_x;
   } vec_cmd_type;

   localparam logic [7:0] GRAPH_START  = 8'd29;
   localparam logic [2:0] TAG_HIGH     = 3'b001;  // 0x20
   localparam logic [2:0] TAG_Y_LOW    = 3'b011;  // 0x60
   localparam logic [2:0] TAG_X_LOW    = 3'b010;  // 0x40
   localparam logic [5:0] UNKNOWN_PART = 6'd63;
   localparam logic [9:0] MAX_COORD    = 10'd1023;
   localparam logic [9:0] PAGE_HEIGHT_RESET = 10'd768;

endpackage

// ===== hw/rtl/brtv_front.sv =====
module brtv_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  brtv_pkg::req_beat_type req_beat,
   input  logic [9:0]            page_height,
   input  logic                  queue_full,
   output logic                  cmd_push,
   output brtv_pkg::vec_cmd_type cmd
);
   import brtv_pkg::*;

   logic [9:0] column_ff, column_in;
   logic [9:0] row_ff, row_in;
   logic       in_run_ff, in_run_in;
   logic [5:0] saved_y_high_ff, saved_y_high_in;
   logic [5:0] saved_y_low_ff, saved_y_low_in;
   logic [5:0] saved_x_high_ff, saved_x_high_in;

   logic       accept;
   logic [9:0] col_e, row_e, y, x1;
   logic       run_e, run_mid, start_run, end_run, addr1_on;
   logic [5:0] syh_e, syl_e, sxh_e;
   logic [5:0] yh, yl, xh0, xh1;
   logic [5:0] syh_m, syl_m, sxh_m;
   logic [NUM_SLOTS-1:0] mask;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;

   always_comb begin
      // page start is applied before the pixel
      if (req_beat.start_of_page) begin
         col_e = '0;
         row_e = '0;
         run_e = 1'b0;
         syh_e = UNKNOWN_PART;
         syl_e = UNKNOWN_PART;
         sxh_e = UNKNOWN_PART;
      end else begin
         col_e = column_ff;
         row_e = row_ff;
         run_e = in_run_ff;
         syh_e = saved_y_high_ff;
         syl_e = saved_y_low_ff;
         sxh_e = saved_x_high_ff;
      end

      y  = (row_e < page_height) ? (page_height - 10'd1 - row_e) : '0;
      x1 = (col_e < MAX_COORD) ? (col_e + 10'd1) : MAX_COORD;
      yh  = {1'b0, y[9:5]};
      yl  = {1'b0, y[4:0]};
      xh0 = {1'b0, col_e[9:5]};
      xh1 = {1'b0, x1[9:5]};

      start_run = req_beat.pixel && !run_e;
      end_run   = !req_beat.pixel && run_e;
      run_mid   = start_run ? 1'b1 : (end_run ? 1'b0 : run_e);
      addr1_on  = req_beat.end_of_line && run_mid;

      mask = '0;
      mask[SLOT_GRAPH_START] = start_run;
      if (start_run || end_run) begin
         mask[SLOT_A0_Y_HIGH] = (yh != syh_e);
         mask[SLOT_A0_Y_LOW]  = (yl != syl_e) || (xh0 != sxh_e);
         mask[SLOT_A0_X_HIGH] = (xh0 != sxh_e);
         mask[SLOT_A0_X_LOW]  = 1'b1;
         syh_m = yh;
         syl_m = yl;
         sxh_m = xh0;
      end else begin
         syh_m = syh_e;
         syl_m = syl_e;
         sxh_m = sxh_e;
      end

      if (addr1_on) begin
         mask[SLOT_A1_Y_HIGH] = (yh != syh_m);
         mask[SLOT_A1_Y_LOW]  = (yl != syl_m) || (xh1 != sxh_m);
         mask[SLOT_A1_X_HIGH] = (xh1 != sxh_m);
         mask[SLOT_A1_X_LOW]  = 1'b1;
         saved_y_high_in = yh;
         saved_y_low_in  = yl;
         saved_x_high_in = xh1;
      end else begin
         saved_y_high_in = syh_m;
         saved_y_low_in  = syl_m;
         saved_x_high_in = sxh_m;
      end

      if (req_beat.end_of_line) begin
         in_run_in = 1'b0;
         column_in = '0;
         row_in    = (row_e < MAX_COORD) ? (row_e + 10'd1) : MAX_COORD;
      end else begin
         in_run_in = run_mid;
         column_in = (col_e < MAX_COORD) ? (col_e + 10'd1) : MAX_COORD;
         row_in    = row_e;
      end
   end

   assign cmd_push      = accept && (mask != '0);
   assign cmd.slot_mask = mask;
   assign cmd.y         = y;
   assign cmd.addr0_x   = col_e;
   assign cmd.addr1_x   = x1;

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         row_ff          <= '0;
         in_run_ff       <= 1'b0;
         saved_y_high_ff <= UNKNOWN_PART;
         saved_y_low_ff  <= UNKNOWN_PART;
         saved_x_high_ff <= UNKNOWN_PART;
      end else if (accept) begin
         column_ff       <= column_in;
         row_ff          <= row_in;
         in_run_ff       <= in_run_in;
         saved_y_high_ff <= saved_y_high_in;
         saved_y_low_ff  <= saved_y_low_in;
         saved_x_high_ff <= saved_x_high_in;
      end
   end

endmodule

// ===== hw/rtl/brtv_queue.sv =====
module brtv_queue #(
   parameter int DEPTH = 4
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  brtv_pkg::vec_cmd_type push_cmd,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output brtv_pkg::vec_cmd_type head_cmd
);
   import brtv_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   vec_cmd_type   slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   assign full       = (count_ff == CW'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = slots_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : (wr_ptr_ff + PW'(1));
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : (rd_ptr_ff + PW'(1));
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hw/rtl/brtv_back.sv =====
module brtv_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  brtv_pkg::vec_cmd_type head_cmd,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output brtv_pkg::rsp_beat_type rsp_beat
);
   import brtv_pkg::*;

   logic [NUM_SLOTS-1:0] sent_ff, sent_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_beat_type         rsp_beat_ff, rsp_beat_in;

   logic [NUM_SLOTS-1:0] remain, pick;
   logic [7:0]           slot_byte [NUM_SLOTS];
   logic [7:0]           sel_byte;
   logic                 pick_last, out_free, load;

   assign remain    = head_cmd.slot_mask & ~sent_ff;
   assign pick      = remain & (~remain + NUM_SLOTS'(1));  // lowest pending slot
   assign pick_last = ((remain & ~pick) == '0);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign load      = out_free && head_valid;
   assign pop       = load && pick_last;

   always_comb begin
      slot_byte[SLOT_GRAPH_START] = GRAPH_START;
      slot_byte[SLOT_A0_Y_HIGH]   = {TAG_HIGH,  head_cmd.y[9:5]};
      slot_byte[SLOT_A0_Y_LOW]    = {TAG_Y_LOW, head_cmd.y[4:0]};
      slot_byte[SLOT_A0_X_HIGH]   = {TAG_HIGH,  head_cmd.addr0_x[9:5]};
      slot_byte[SLOT_A0_X_LOW]    = {TAG_X_LOW, head_cmd.addr0_x[4:0]};
      slot_byte[SLOT_A1_Y_HIGH]   = {TAG_HIGH,  head_cmd.y[9:5]};
      slot_byte[SLOT_A1_Y_LOW]    = {TAG_Y_LOW, head_cmd.y[4:0]};
      slot_byte[SLOT_A1_X_HIGH]   = {TAG_HIGH,  head_cmd.addr1_x[9:5]};
      slot_byte[SLOT_A1_X_LOW]    = {TAG_X_LOW, head_cmd.addr1_x[4:0]};
      sel_byte = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         sel_byte = sel_byte | ({8{pick[i]}} & slot_byte[i]);
      end
   end

   always_comb begin
      sent_in      = sent_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_beat_in  = rsp_beat_ff;
      if (out_free) begin
         rsp_valid_in = head_valid;
      end
      if (load) begin
         rsp_beat_in.out_byte = sel_byte;
         rsp_beat_in.last     = pick_last;
         sent_in              = pick_last ? '0 : (sent_ff | pick);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         sent_ff      <= sent_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_beat  = rsp_beat_ff;

endmodule

// ===== hw/rtl/bitmap_runs_to_vector_terminal_stream_core.sv =====
// Raster-to-vector terminal stream encoder. Takes a 1-bit raster one pixel
// per beat (left to right, top row first) and emits the graph-mode byte
// stream: graph-start (29) plus the start address when a run of set pixels
// opens, and the exclusive end address at the first clear pixel or the end
// of the row. Addresses are 10-bit, sent as the shortened Y-high / Y-low /
// X-high / X-low sequence. Each output beat is one byte; "last" flags the
// final byte caused by an input pixel, and pixels that cause no bytes send
// nothing. The input takes one pixel per cycle while the queue is not full; a
// pixel at a run edge produces 1 to 9 bytes, and the byte sequencer sends one
// byte per cycle while the output is not stalled. The QUEUE_DEPTH command queue
// between classifier and sequencer absorbs those bursts; req_stall rises only
// when it is full. Commands are registered in the queue, bytes in the output
// register. The user writes page_height through csr_write_en/csr_write_data
// only while the block is idle (reset 768); the block does not enforce this.
module bitmap_runs_to_vector_terminal_stream_core #(
   parameter int QUEUE_DEPTH = 4   // commands in flight, 2 or more
) (
   input  logic                   clock,
   input  logic                   reset,
   // pixel input
   input  logic                   req_valid,
   output logic                   req_stall,
   input  brtv_pkg::req_beat_type req_beat,
   // byte output
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output brtv_pkg::rsp_beat_type rsp_beat,
   // page_height register
   input  logic                   csr_write_en,
   input  logic [9:0]             csr_write_data
);
   import brtv_pkg::*;

   logic [9:0]  page_height_ff;

   logic        cmd_push;
   vec_cmd_type cmd;
   logic        queue_full;
   logic        head_valid;
   vec_cmd_type head_cmd;
   logic        pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         page_height_ff <= PAGE_HEIGHT_RESET;
      end else if (csr_write_en) begin
         page_height_ff <= csr_write_data;
      end
   end

   // front: tracks column/row/run state and saved address bytes, builds
   // one command (which byte slots to send) per pixel
   brtv_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_beat    (req_beat),
      .page_height (page_height_ff),
      .queue_full  (queue_full),
      .cmd_push    (cmd_push),
      .cmd         (cmd)
   );

   // command queue decoupling the two sides
   brtv_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (cmd_push),
      .push_cmd   (cmd),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // back: walks the head command's slots, one byte per beat, into the
   // output register
   brtv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_beat   (rsp_beat)
   );

endmodule
